/* sv/dcdw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcdw_pkg
// Shared constants, tables and types for the day count to date converter.
// ----------------------------------------------------------------------------
package dcdw_pkg;

  // Supported span: BASE_YEAR through BASE_YEAR + MAX_YEARS - 1
  localparam int unsigned MAX_YEARS   = 256;
  localparam int unsigned BASE_YEAR   = 2000;
  localparam int unsigned DAYS_LEAP   = 366;
  localparam int unsigned DAYS_COMMON = 365;
  localparam int unsigned WEEK_DAYS   = 7;
  localparam int unsigned MONTHS      = 12;
  localparam int unsigned CENT_YEARS  = 100;

  // Leap years in the span; the span starts on a 400-year boundary
  localparam int unsigned SPAN_LEAPS = (MAX_YEARS + 3) / 4 - (MAX_YEARS + 99) / 100
                                       + (MAX_YEARS + 399) / 400;
  localparam int unsigned TOTAL_DAYS = DAYS_COMMON * MAX_YEARS + SPAN_LEAPS;

  // Century and four-year block lengths
  localparam int unsigned CENT_LONG  = 36525;  // century that opens with a leap year
  localparam int unsigned CENT_SHORT = 36524;  // century that opens with a common year
  localparam int unsigned QUAD_DAYS  = 1461;

  // Reciprocal of QUAD_DAYS: estimate is exact or one too large
  localparam int unsigned RECIP_QUAD  = 2871;
  localparam int unsigned RECIP_SHIFT = 22;

  // Field and internal widths
  localparam int unsigned DAY_W   = 17;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned DOY_W   = 9;

  // Days before the start of each month in a common year
  localparam logic [DOY_W-1:0] MONTH_START [MONTHS+1] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  // Month decode result
  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DOY_W-1:0]   start;
  } month_sel_t;

endpackage
`default_nettype wire

/* sv/dcdw_month.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcdw_month
// Month decode: finds the month holding a zero-based day of year and the
// day of year at which that month starts, under the leap rule given.
// ----------------------------------------------------------------------------
module dcdw_month (
  input  logic [dcdw_pkg::DOY_W-1:0] doy,
  input  logic                       leap,
  output dcdw_pkg::month_sel_t       sel
);
  import dcdw_pkg::*;

  logic [DOY_W-1:0]   mend;
  logic [MONTH_W-1:0] mon;

  // Pick the first month whose end lies past the day of year
  always_comb begin
    mon  = MONTH_W'(MONTHS);
    mend = '0;
    for (int k = MONTHS; k >= 1; k--) begin
      mend = MONTH_START[k] + DOY_W'(leap && (k >= 2));
      if (doy < mend) begin
        mon = MONTH_W'(k);
      end
    end
    sel.month = mon;
    sel.start = MONTH_START[mon - MONTH_W'(1)] + DOY_W'(leap && (mon >= MONTH_W'(3)));
  end

endmodule
`default_nettype wire

/* sv/day_count_to_date_weekday.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// day_count_to_date_weekday
// Converts a count of days since 2000-01-01 into Gregorian year, month,
// day of month and weekday (0 = Saturday), with an out-of-range flag.
//
//   channel  direction  handshake            payload
//   in_      request    in_valid/in_ready    in_day_count
//   out_     result     out_valid/out_ready  out_year, out_month,
//                                            out_day_of_month, out_weekday,
//                                            out_out_of_range
//
// Six register stages: century split, block quotient estimate, quotient
// correction, year within block, month decode, day of month. One request
// enters per cycle while out_ready is high; out_valid is the last stage valid.
// rst_n clears only the stage valid bits. A stall on out_ready holds each full
// stage with no empty stage after it; a stage takes a new request when empty or drained.
// ----------------------------------------------------------------------------
module day_count_to_date_weekday (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dcdw_pkg::DAY_W-1:0]   in_day_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dcdw_pkg::YEAR_W-1:0]  out_year,
  output logic [dcdw_pkg::MONTH_W-1:0] out_month,
  output logic [dcdw_pkg::DOM_W-1:0]   out_day_of_month,
  output logic [dcdw_pkg::WDAY_W-1:0]  out_weekday,
  output logic                         out_out_of_range
);
  import dcdw_pkg::*;

  localparam int unsigned NSTG = 6;
  localparam logic [DAY_W-1:0] C1_START = DAY_W'(CENT_LONG);
  localparam logic [DAY_W-1:0] C2_START = DAY_W'(CENT_LONG + CENT_SHORT);
  localparam logic [DAY_W-1:0] C3_START = DAY_W'(CENT_LONG + 2 * CENT_SHORT);
  localparam logic [31:0]      END_DAY  = 32'(TOTAL_DAYS);
  localparam logic [10:0]      Y1_START = 11'(DAYS_LEAP);
  localparam logic [10:0]      Y2_START = 11'(DAYS_LEAP + DAYS_COMMON);
  localparam logic [10:0]      Y3_START = 11'(DAYS_LEAP + 2 * DAYS_COMMON);

  typedef struct packed {
    logic [1:0]        cent;
    logic              short_cent;
    logic [15:0]       rc;
    logic              oor;
    logic [WDAY_W-1:0] wday;
  } st1_t;

  typedef struct packed {
    logic [1:0]        cent;
    logic              short_cent;
    logic [15:0]       rc;
    logic [4:0]        qest;
    logic              oor;
    logic [WDAY_W-1:0] wday;
  } st2_t;

  typedef struct packed {
    logic [1:0]        cent;
    logic              short_cent;
    logic [4:0]        q;
    logic [10:0]       r;
    logic              oor;
    logic [WDAY_W-1:0] wday;
  } st3_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [DOY_W-1:0]  doy;
    logic              leap;
    logic              oor;
    logic [WDAY_W-1:0] wday;
  } st4_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOY_W-1:0]   start;
    logic [DOY_W-1:0]   doy;
    logic               oor;
    logic [WDAY_W-1:0]  wday;
  } st5_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   dom;
    logic               oor;
    logic [WDAY_W-1:0]  wday;
  } st6_t;

  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   rdy;
  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  st4_t s4_r, s4_nxt;
  st5_t s5_r, s5_nxt;
  st6_t s6_r, s6_nxt;

  logic [DAY_W-1:0] rc_full;
  logic [5:0]       fold1;
  logic [3:0]       fold2;
  logic [27:0]      prod;
  logic [15:0]      tq;
  logic             over;
  logic             short_blk;
  logic [1:0]       yb;
  logic [10:0]      rdoy;
  month_sel_t       msel;
  logic [DOY_W-1:0] dom_w;

  // Stage can load when empty or when its content moves on
  always_comb begin
    rdy[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: split off centuries, range check, weekday by octal digit folding
  always_comb begin
    if (in_day_count >= C3_START) begin
      s1_nxt.cent = 2'd3;
      rc_full     = in_day_count - C3_START + DAY_W'(1);
    end else if (in_day_count >= C2_START) begin
      s1_nxt.cent = 2'd2;
      rc_full     = in_day_count - C2_START + DAY_W'(1);
    end else if (in_day_count >= C1_START) begin
      s1_nxt.cent = 2'd1;
      rc_full     = in_day_count - C1_START + DAY_W'(1);
    end else begin
      s1_nxt.cent = 2'd0;
      rc_full     = in_day_count;
    end
    s1_nxt.short_cent = (s1_nxt.cent != 2'd0);
    s1_nxt.rc         = rc_full[15:0];
    s1_nxt.oor        = ({15'd0, in_day_count} >= END_DAY);
    fold1 = 6'(in_day_count[2:0]) + 6'(in_day_count[5:3]) + 6'(in_day_count[8:6])
          + 6'(in_day_count[11:9]) + 6'(in_day_count[14:12]) + 6'(in_day_count[16:15]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    s1_nxt.wday = (fold2 >= 4'(WEEK_DAYS)) ? WDAY_W'(fold2 - 4'(WEEK_DAYS))
                                           : WDAY_W'(fold2);
  end

  // Stage 2: estimate four-year block index by reciprocal multiply
  always_comb begin
    prod            = 28'(s1_r.rc) * 28'(RECIP_QUAD);
    s2_nxt.cent       = s1_r.cent;
    s2_nxt.short_cent = s1_r.short_cent;
    s2_nxt.rc         = s1_r.rc;
    s2_nxt.qest       = 5'(prod >> RECIP_SHIFT);
    s2_nxt.oor        = s1_r.oor;
    s2_nxt.wday       = s1_r.wday;
  end

  // Stage 3: correct the estimate, form day within block
  always_comb begin
    tq   = 16'(s2_r.qest) * 16'(QUAD_DAYS);
    over = (tq > s2_r.rc);
    s3_nxt.cent       = s2_r.cent;
    s3_nxt.short_cent = s2_r.short_cent;
    s3_nxt.q          = over ? (s2_r.qest - 5'd1) : s2_r.qest;
    s3_nxt.r          = over ? 11'(s2_r.rc - tq + 16'(QUAD_DAYS)) : 11'(s2_r.rc - tq);
    s3_nxt.oor        = s2_r.oor;
    s3_nxt.wday       = s2_r.wday;
  end

  // Stage 4: year within block, day of year, leap flag and full year
  always_comb begin
    short_blk = s3_r.short_cent && (s3_r.q == 5'd0);
    if (s3_r.r < Y1_START) begin
      yb   = 2'd0;
      rdoy = s3_r.r - 11'(short_blk);
    end else if (s3_r.r < Y2_START) begin
      yb   = 2'd1;
      rdoy = s3_r.r - Y1_START;
    end else if (s3_r.r < Y3_START) begin
      yb   = 2'd2;
      rdoy = s3_r.r - Y2_START;
    end else begin
      yb   = 2'd3;
      rdoy = s3_r.r - Y3_START;
    end
    s4_nxt.leap = (yb == 2'd0) && !short_blk;
    s4_nxt.doy  = rdoy[DOY_W-1:0];
    s4_nxt.year = YEAR_W'(BASE_YEAR) + YEAR_W'(s3_r.cent) * YEAR_W'(CENT_YEARS)
                + YEAR_W'({s3_r.q, 2'b00}) + YEAR_W'(yb);
    s4_nxt.oor  = s3_r.oor;
    s4_nxt.wday = s3_r.wday;
  end

  // Stage 5: month decode
  dcdw_month u_month (
    .doy  (s4_r.doy),
    .leap (s4_r.leap),
    .sel  (msel)
  );

  always_comb begin
    s5_nxt.year  = s4_r.year;
    s5_nxt.month = msel.month;
    s5_nxt.start = msel.start;
    s5_nxt.doy   = s4_r.doy;
    s5_nxt.oor   = s4_r.oor;
    s5_nxt.wday  = s4_r.wday;
  end

  // Stage 6: day of month, drop date fields when out of range
  always_comb begin
    dom_w        = s5_r.doy - s5_r.start + DOY_W'(1);
    s6_nxt.year  = s5_r.oor ? '0 : s5_r.year;
    s6_nxt.month = s5_r.oor ? '0 : s5_r.month;
    s6_nxt.dom   = s5_r.oor ? '0 : dom_w[DOM_W-1:0];
    s6_nxt.oor   = s5_r.oor;
    s6_nxt.wday  = s5_r.wday;
  end

  // Load stage payloads
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (rdy[1] && vld_r[0]) begin
      s2_r <= s2_nxt;
    end
    if (rdy[2] && vld_r[1]) begin
      s3_r <= s3_nxt;
    end
    if (rdy[3] && vld_r[2]) begin
      s4_r <= s4_nxt;
    end
    if (rdy[4] && vld_r[3]) begin
      s5_r <= s5_nxt;
    end
    if (rdy[5] && vld_r[4]) begin
      s6_r <= s6_nxt;
    end
  end

  assign out_valid        = vld_r[NSTG-1];
  assign out_year         = s6_r.year;
  assign out_month        = s6_r.month;
  assign out_day_of_month = s6_r.dom;
  assign out_weekday      = s6_r.wday;
  assign out_out_of_range = s6_r.oor;

endmodule
`default_nettype wire

/* bench/tb_day_count_to_date_weekday.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_day_count_to_date_weekday
// Self-checking bench for the day count to date converter. A short directed
// table covers leap days, century years, the end of the span and the input
// extremes. Random requests follow, weighted toward the supported span. Both
// handshakes idle at random, except for a stretch that runs at full rate.
// Every result is compared field by field with a date computed in the bench or given in the table.
// ----------------------------------------------------------------------------
module tb_day_count_to_date_weekday;
  import dcdw_pkg::*;

  // Date fields as the block reports them
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   dom;
    logic [WDAY_W-1:0]  weekday;
    logic               oor;
  } date_t;

  // One accepted request and the date it should produce
  typedef struct packed {
    logic [DAY_W-1:0] cnt;
    date_t            date;
  } pending_t;

  // Directed row: when fixed is set, the date is taken as written
  typedef struct packed {
    logic [DAY_W-1:0] cnt;
    logic             fixed;
    date_t            date;
  } dir_row_t;

  localparam int unsigned N_DIR    = 19;
  localparam int unsigned N_RANDOM = 880;
  localparam int unsigned SPAN_END = 93502;  // first day past the span

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{17'd0,      1'b1, '{12'd2000, 4'd1,  5'd1,  3'd0, 1'b0}},  // first day, Saturday
    '{17'd1,      1'b0, '0},
    '{17'd30,     1'b0, '0},  // end of January
    '{17'd31,     1'b0, '0},
    '{17'd58,     1'b0, '0},
    '{17'd59,     1'b0, '0},  // leap day in a 400-year
    '{17'd60,     1'b0, '0},
    '{17'd365,    1'b0, '0},  // last day of a leap year
    '{17'd366,    1'b0, '0},
    '{17'd1154,   1'b0, '0},  // common year, Feb 28 then Mar 1
    '{17'd1155,   1'b0, '0},
    '{17'd1520,   1'b0, '0},  // ordinary leap day
    '{17'd36583,  1'b0, '0},  // century year without a leap day
    '{17'd36584,  1'b0, '0},
    '{17'd65536,  1'b0, '0},  // top bit alone
    '{17'd93501,  1'b1, '{12'd2255, 4'd12, 5'd31, 3'd2, 1'b0}},  // last day of the span
    '{17'd93502,  1'b1, '{12'd0,    4'd0,  5'd0,  3'd3, 1'b1}},  // first day past the span
    '{17'd100000, 1'b0, '0},
    '{17'd131071, 1'b1, '{12'd0,    4'd0,  5'd0,  3'd3, 1'b1}}   // all ones
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [DAY_W-1:0]   in_day_count;
  logic               out_valid;
  logic               out_ready;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [DOM_W-1:0]   out_day_of_month;
  logic [WDAY_W-1:0]  out_weekday;
  logic               out_out_of_range;

  pending_t    pending_dates [$];
  int unsigned n_mismatch = 0;
  logic        calm = 1'b0;  // suppress idling on both sides

  day_count_to_date_weekday DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_day_count     (in_day_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_weekday      (out_weekday),
    .out_out_of_range (out_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("[day_count_to_date_weekday] ERROR");
    $finish;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    n_mismatch++;
  endtask

  // Walk the years, then the months, to find the calendar date of a count
  function automatic date_t calendar_date(input logic [DAY_W-1:0] cnt);
    date_t       d;
    int unsigned rest;
    int unsigned yr;
    int unsigned mo;
    int unsigned mlens [12];
    logic        leap;
    d         = '0;
    d.weekday = WDAY_W'(cnt % WEEK_DAYS);
    d.oor     = 1'b1;
    rest      = cnt;
    yr        = BASE_YEAR;
    while (d.oor && yr < BASE_YEAR + MAX_YEARS) begin
      leap = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
      if (rest < (leap ? DAYS_LEAP : DAYS_COMMON)) begin
        mlens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (leap) mlens[1] = 29;
        mo = 0;
        while (rest >= mlens[mo]) begin
          rest -= mlens[mo];
          mo++;
        end
        d.oor   = 1'b0;
        d.year  = YEAR_W'(yr);
        d.month = MONTH_W'(mo + 1);
        d.dom   = DOM_W'(rest + 1);
      end else begin
        rest -= leap ? DAYS_LEAP : DAYS_COMMON;
        yr++;
      end
    end
    return d;
  endfunction

  // Present one request, hold it until taken, then queue its date
  task automatic send_request(input logic [DAY_W-1:0] cnt, input date_t date);
    logic taken;
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_day_count <= cnt;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    pending_dates.push_back('{cnt, date});
  endtask

  // Stall the result side at random
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  // Check each result taken on the next edge against the oldest date
  initial begin
    pending_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_dates.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: year %0d month %0d",
                                    out_year, out_month));
        end else begin
          want = pending_dates.pop_front();
          if (out_year !== want.date.year)
            report_mismatch($sformatf("count %0d year %0d, want %0d",
                                      want.cnt, out_year, want.date.year));
          if (out_month !== want.date.month)
            report_mismatch($sformatf("count %0d month %0d, want %0d",
                                      want.cnt, out_month, want.date.month));
          if (out_day_of_month !== want.date.dom)
            report_mismatch($sformatf("count %0d day %0d, want %0d",
                                      want.cnt, out_day_of_month, want.date.dom));
          if (out_weekday !== want.date.weekday)
            report_mismatch($sformatf("count %0d weekday %0d, want %0d",
                                      want.cnt, out_weekday, want.date.weekday));
          if (out_out_of_range !== want.date.oor)
            report_mismatch($sformatf("count %0d out_of_range %0b, want %0b",
                                      want.cnt, out_out_of_range, want.date.oor));
        end
      end
    end
  end

  // Reset, directed table, random requests, drain, verdict
  initial begin
    logic [DAY_W-1:0] cnt;
    int unsigned      pick;
    int unsigned      waited;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_day_count <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < N_DIR; i++) begin
      send_request(DIR_ROWS[i].cnt,
                   DIR_ROWS[i].fixed ? DIR_ROWS[i].date : calendar_date(DIR_ROWS[i].cnt));
    end

    // Random counts, mostly inside the span; one stretch runs at full rate
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 300 && i < 450);
      pick = $urandom_range(0, 99);
      if (pick < 60)
        cnt = DAY_W'($urandom_range(0, SPAN_END - 1));
      else if (pick < 70)
        cnt = DAY_W'($urandom_range(SPAN_END - 12, SPAN_END + 12));
      else if (pick < 80)
        cnt = DAY_W'($urandom_range(SPAN_END, 131071));
      else
        cnt = DAY_W'($urandom);
      send_request(cnt, calendar_date(cnt));
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Drain outstanding results, then let the pipeline settle
    waited = 0;
    while (pending_dates.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_dates.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_dates.size()));
    repeat (20) @(posedge clk);

    if (n_mismatch == 0)
      $display("[day_count_to_date_weekday] OK");
    else
      $display("[day_count_to_date_weekday] ERROR");
    $finish;
  end

endmodule

/* day_count_to_date_weekday.f */
sv/dcdw_pkg.sv
sv/dcdw_month.sv
sv/day_count_to_date_weekday.sv
bench/tb_day_count_to_date_weekday.sv
